// ===== src/hrlhe_pkg.sv =====
package hrlhe_pkg;

   localparam int QUEUE_DEPTH  = 4;
   localparam int PREFIX_DEPTH = 5;
   localparam int HOST_LEN     = 6;

   localparam logic [7:0] CHAR_NUL      = 8'h00;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_H        = "H";
   localparam logic [7:0] CHAR_PRINT_LO = 8'd32;
   localparam logic [7:0] CHAR_PRINT_HI = 8'd126;

   localparam logic [1:0] KIND_LINE    = 2'd0;
   localparam logic [1:0] KIND_HOST    = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   typedef enum logic [1:0] {
      FLUSH_NONE = 2'd0,
      FLUSH_GET  = 2'd1,
      FLUSH_POST = 2'd2,
      FLUSH_HTTP = 2'd3
   } flush_sel_type;

   typedef struct packed {
      flush_sel_type flush_sel;
      logic          line_en;
      logic          host_en;
      logic          last;
      logic          line_host;
      logic          sum_http;
      logic          sum_host;
      logic [7:0]    data;
   } cmd_type;

   function automatic logic [2:0] prefix_len(flush_sel_type sel);
      logic [2:0] len;
      case (sel)
         FLUSH_GET: len = 3'd4;
         FLUSH_POST,
         FLUSH_HTTP: len = 3'd5;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] prefix_char(flush_sel_type sel, logic [2:0] idx);
      logic [7:0] ch;
      ch = CHAR_NUL;
      case (sel)
         FLUSH_GET: begin
            case (idx)
               3'd0: ch = "G";
               3'd1: ch = "E";
               3'd2: ch = "T";
               3'd3: ch = " ";
               default: ch = CHAR_NUL;
            endcase
         end
         FLUSH_POST: begin
            case (idx)
               3'd0: ch = "P";
               3'd1: ch = "O";
               3'd2: ch = "S";
               3'd3: ch = "T";
               3'd4: ch = " ";
               default: ch = CHAR_NUL;
            endcase
         end
         FLUSH_HTTP: begin
            case (idx)
               3'd0: ch = "H";
               3'd1: ch = "T";
               3'd2: ch = "T";
               3'd3: ch = "P";
               3'd4: ch = "/";
               default: ch = CHAR_NUL;
            endcase
         end
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] host_char(logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = "H";
         3'd1: ch = "o";
         3'd2: ch = "s";
         3'd3: ch = "t";
         3'd4: ch = ":";
         3'd5: ch = " ";
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

// ===== src/hrlhe_queue.sv =====
module hrlhe_queue #(
   parameter int Depth = hrlhe_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrlhe_pkg::cmd_type  push_data,
   output logic                push_ready,
   input  logic                pop,
   output logic                pop_valid,
   output hrlhe_pkg::cmd_type  pop_data
);
   import hrlhe_pkg::*;

   localparam int IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountW = $clog2(Depth + 1);

   cmd_type           mem_ff [Depth];
   logic [IdxW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IdxW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign push_ready = (count_ff != CountW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IdxW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IdxW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/hrlhe_front.sv =====
module hrlhe_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output logic                push,
   output hrlhe_pkg::cmd_type  cmd
);
   import hrlhe_pkg::*;

   typedef enum logic [2:0] {
      HOST_SEARCH = 3'b001,
      HOST_VALUE  = 3'b010,
      HOST_DONE   = 3'b100
   } host_phase_type;

   logic [2:0]     pos_ff, pos_in;
   logic [2:0]     cand_ff, cand_in;
   logic           http_ff, http_in;
   logic           line_done_ff, line_done_in;
   logic [2:0]     host_cnt_ff, host_cnt_in;
   host_phase_type phase_ff, phase_in;

   logic           eol;
   logic [2:0]     alive;
   flush_sel_type  match_sel;
   flush_sel_type  sel_c;

   always_comb begin
      pos_in       = pos_ff;
      cand_in      = cand_ff;
      http_in      = http_ff;
      line_done_in = line_done_ff;
      host_cnt_in  = host_cnt_ff;
      phase_in     = phase_ff;
      alive        = '0;
      match_sel    = FLUSH_NONE;
      sel_c        = FLUSH_NONE;
      eol          = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);

      cmd           = '0;
      cmd.flush_sel = FLUSH_NONE;
      cmd.data      = data_byte;
      cmd.last      = last_byte;

      if (http_ff) begin
         cmd.line_host = (phase_ff != HOST_SEARCH);
         if (!line_done_ff) begin
            if (eol) begin
               line_done_in = 1'b1;
            end else if (data_byte inside {[CHAR_PRINT_LO:CHAR_PRINT_HI]}) begin
               cmd.line_en = 1'b1;
            end
         end
         case (phase_ff)
            HOST_SEARCH: begin
               if (host_char(host_cnt_ff) == data_byte) begin
                  if (host_cnt_ff == 3'(HOST_LEN - 1)) begin
                     host_cnt_in = '0;
                     phase_in    = HOST_VALUE;
                  end else begin
                     host_cnt_in = host_cnt_ff + 3'd1;
                  end
               end else begin
                  host_cnt_in = (data_byte == CHAR_H) ? 3'd1 : 3'd0;
               end
            end
            HOST_VALUE: begin
               if (eol || data_byte == CHAR_NUL) begin
                  phase_in = HOST_DONE;
               end else begin
                  cmd.host_en = 1'b1;
               end
            end
            default: ;
         endcase
      end else if (cand_ff != '0) begin
         if (pos_ff >= 3'(PREFIX_DEPTH)) begin
            cand_in = '0;
         end else begin
            for (int c = 0; c < 3; c++) begin
               sel_c = flush_sel_type'(2'(c + 1));
               alive[c] = cand_ff[c] && (pos_ff < prefix_len(sel_c))
                          && (prefix_char(sel_c, pos_ff) == data_byte);
               if (alive[c] && (pos_ff == prefix_len(sel_c) - 3'd1)) begin
                  match_sel = sel_c;
               end
            end
            cand_in = alive;
            pos_in  = pos_ff + 3'd1;
            if (match_sel != FLUSH_NONE) begin
               http_in       = 1'b1;
               cmd.flush_sel = match_sel;
            end
         end
      end

      cmd.sum_http = http_in;
      cmd.sum_host = (phase_in != HOST_SEARCH);

      push = fire && ((cmd.flush_sel != FLUSH_NONE) || cmd.line_en || cmd.host_en
                      || last_byte);

      // clear all payload state after the final byte
      if (last_byte) begin
         pos_in       = '0;
         cand_in      = 3'b111;
         http_in      = 1'b0;
         line_done_in = 1'b0;
         host_cnt_in  = '0;
         phase_in     = HOST_SEARCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cand_ff      <= 3'b111;
         http_ff      <= 1'b0;
         line_done_ff <= 1'b0;
         host_cnt_ff  <= '0;
         phase_ff     <= HOST_SEARCH;
      end else if (fire) begin
         pos_ff       <= pos_in;
         cand_ff      <= cand_in;
         http_ff      <= http_in;
         line_done_ff <= line_done_in;
         host_cnt_ff  <= host_cnt_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

// ===== src/hrlhe_back.sv =====
module hrlhe_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  hrlhe_pkg::cmd_type  q_data,
   output logic                q_pop,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [1:0]          rsp_out_kind,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_is_http,
   output logic                rsp_host_found,
   output logic                rsp_end_of_run
);
   import hrlhe_pkg::*;

   cmd_type    cur_ff, cur_in, cur_next;
   logic [2:0] idx_ff, idx_in, idx_next;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       http_ff, http_in;
   logic       host_ff, host_in;
   logic       eor_ff, eor_in;

   logic       busy;
   logic       emit;
   logic       rest;
   logic       flush_end;

   always_comb begin
      busy      = (cur_ff.flush_sel != FLUSH_NONE) || cur_ff.line_en || cur_ff.host_en
                  || cur_ff.last;
      emit      = busy && (!rsp_valid_ff || rsp_ready);
      flush_end = (idx_ff == prefix_len(cur_ff.flush_sel) - 3'd1);
      cur_next  = cur_ff;
      idx_next  = idx_ff;

      if (cur_ff.flush_sel != FLUSH_NONE) begin
         kind_in  = KIND_LINE;
         byte_in  = prefix_char(cur_ff.flush_sel, idx_ff);
         http_in  = 1'b1;
         host_in  = 1'b0;
         rest     = !flush_end || cur_ff.line_en || cur_ff.host_en || cur_ff.last;
         idx_next = idx_ff + 3'd1;
         if (flush_end) begin
            cur_next.flush_sel = FLUSH_NONE;
         end
      end else if (cur_ff.line_en) begin
         kind_in  = KIND_LINE;
         byte_in  = cur_ff.data;
         http_in  = 1'b1;
         host_in  = cur_ff.line_host;
         rest     = cur_ff.host_en || cur_ff.last;
         cur_next.line_en = 1'b0;
      end else if (cur_ff.host_en) begin
         kind_in  = KIND_HOST;
         byte_in  = cur_ff.data;
         http_in  = 1'b1;
         host_in  = 1'b1;
         rest     = cur_ff.last;
         cur_next.host_en = 1'b0;
      end else begin
         kind_in  = KIND_SUMMARY;
         byte_in  = '0;
         http_in  = cur_ff.sum_http;
         host_in  = cur_ff.sum_host;
         rest     = 1'b0;
         cur_next.last = 1'b0;
      end
      eor_in = !rest;

      cur_in = emit ? cur_next : cur_ff;
      idx_in = emit ? idx_next : idx_ff;

      q_pop = q_valid && (!busy || (emit && !rest));
      if (q_pop) begin
         cur_in = q_data;
         idx_in = '0;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         http_ff <= http_in;
         host_ff <= host_in;
         eor_ff  <= eor_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_kind   = kind_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_is_http    = http_ff;
   assign rsp_host_found = host_ff;
   assign rsp_end_of_run = eor_ff;

endmodule

// ===== src/http_request_line_host_extractor.sv =====
// Channel   Direction  Ports                                         Transfer
// req       in         req_data_byte, req_last_byte                  req_valid & req_ready
// rsp       out        rsp_out_kind, rsp_out_byte, rsp_is_http,      rsp_valid & rsp_ready
//                      rsp_host_found, rsp_end_of_run
//
// One payload byte is taken per cycle while req_ready is high; it is classified in
// the same cycle and its records are queued. The output register sends one record
// per cycle while rsp_ready is high; a byte causes up to six records (a prefix flush
// plus the summary). The command queue absorbs bursts and req_ready drops only when
// it is full. Records pass the command queue, the back end's command register and the
// output register in turn. Reset is synchronous and active high; no clearing pass.
module http_request_line_host_extractor #(
   parameter int QueueDepth = hrlhe_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_http,
   output logic       rsp_host_found,
   output logic       rsp_end_of_run
);
   import hrlhe_pkg::*;

   logic    req_fire;
   logic    q_push;
   logic    q_push_ready;
   cmd_type q_push_data;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_data;

   assign req_ready = q_push_ready;
   assign req_fire  = req_valid && req_ready;

   hrlhe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .fire      (req_fire),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (q_push),
      .cmd       (q_push_data)
   );

   hrlhe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .push_ready (q_push_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   hrlhe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_http    (rsp_is_http),
      .rsp_host_found (rsp_host_found),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

// ===== src/hrlhe_checker.sv =====
module hrlhe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_out_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_is_http,
   input logic       rsp_host_found,
   input logic       rsp_end_of_run
);
   import hrlhe_pkg::*;

   // hold the record while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_kind)
         && $stable(rsp_out_byte) && $stable(rsp_end_of_run))
      else $error("rsp record changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == KIND_LINE || rsp_out_kind == KIND_HOST)
         |-> rsp_is_http)
      else $error("character record outside an HTTP payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_SUMMARY |-> rsp_end_of_run && rsp_out_byte == '0)
      else $error("summary record malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_HOST |-> rsp_host_found)
      else $error("host character without host header");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_kind == KIND_LINE || rsp_out_kind == KIND_HOST
         || rsp_out_kind == KIND_SUMMARY)
      else $error("record kind out of range");

endmodule

bind http_request_line_host_extractor hrlhe_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_kind   (rsp_out_kind),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_is_http    (rsp_is_http),
   .rsp_host_found (rsp_host_found),
   .rsp_end_of_run (rsp_end_of_run)
);

// ===== tb/http_request_line_host_extractor_test.sv =====
`timescale 1ns / 1ps

module http_request_line_host_extractor_test;
   import hrlhe_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 360;
   localparam int DRAIN_CYCLES  = 16;

   localparam logic [1:0] HOST_SEARCHING = 2'd0;
   localparam logic [1:0] HOST_IN_VALUE  = 2'd1;
   localparam logic [1:0] HOST_DONE      = 2'd2;

   localparam logic [119:0] CAND_TEXT = {"GET ", 8'h00, "POST ", "HTTP/"};
   localparam logic [47:0]  HOST_TEXT = "Host: ";

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] chr;
      logic       http;
      logic       host;
      logic       eor;
   } extract_rec_type;

   typedef struct packed {
      logic [7:0]      b;
      logic            last;
      logic            fixed;
      extract_rec_type want;
   } stim_row_type;

   localparam extract_rec_type SUM_NOT_HTTP  = {KIND_SUMMARY, 8'h00, 1'b0, 1'b0, 1'b1};
   localparam extract_rec_type SUM_HTTP      = {KIND_SUMMARY, 8'h00, 1'b1, 1'b0, 1'b1};
   localparam extract_rec_type SUM_HTTP_HOST = {KIND_SUMMARY, 8'h00, 1'b1, 1'b1, 1'b1};

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_last_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_http;
   logic       rsp_host_found;
   logic       rsp_end_of_run;

   extract_rec_type awaited_recs[$];
   stim_row_type    directed_rows[$];
   logic [7:0]      payload_bytes[$];

   logic [2:0] pfx_pos;
   logic [2:0] pfx_alive;
   logic [7:0] pfx_bytes [PREFIX_DEPTH];
   logic       seen_http;
   logic       line_done;
   logic [2:0] host_cnt;
   logic [1:0] host_state;

   int  mismatches  = 0;
   int  cycle_count = 0;
   bit  req_calm    = 1'b0;

   http_request_line_host_extractor dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .req_last_byte  (req_last_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_http    (rsp_is_http),
      .rsp_host_found (rsp_host_found),
      .rsp_end_of_run (rsp_end_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic logic [7:0] cand_char(input int c, input int i);
      return CAND_TEXT[8 * (14 - 5 * c - i) +: 8];
   endfunction

   function automatic int cand_len(input int c);
      return (c == 0) ? 4 : 5;
   endfunction

   function automatic void clear_extractor();
      pfx_pos    = 3'd0;
      pfx_alive  = 3'b111;
      seen_http  = 1'b0;
      line_done  = 1'b0;
      host_cnt   = 3'd0;
      host_state = HOST_SEARCHING;
   endfunction

   function automatic void emit_rec(input logic [1:0] kind, input logic [7:0] chr);
      extract_rec_type r;
      r.kind = kind;
      r.chr  = chr;
      r.http = seen_http;
      r.host = (host_state != HOST_SEARCHING);
      r.eor  = 1'b0;
      awaited_recs.push_back(r);
   endfunction

   function automatic void scan_http_byte(input logic [7:0] b);
      logic eol;
      eol = (b == CHAR_CR) || (b == CHAR_LF);
      if (!line_done) begin
         if (eol)
            line_done = 1'b1;
         else if (b >= CHAR_PRINT_LO && b <= CHAR_PRINT_HI)
            emit_rec(KIND_LINE, b);
      end
      if (host_state == HOST_SEARCHING) begin
         if (host_cnt < HOST_LEN && HOST_TEXT[8 * (5 - host_cnt) +: 8] == b) begin
            host_cnt = host_cnt + 3'd1;
            if (host_cnt >= HOST_LEN) begin
               host_cnt   = 3'd0;
               host_state = HOST_IN_VALUE;
            end
         end else begin
            host_cnt = (b == CHAR_H) ? 3'd1 : 3'd0;
         end
      end else if (host_state == HOST_IN_VALUE) begin
         if (eol || b == CHAR_NUL)
            host_state = HOST_DONE;
         else
            emit_rec(KIND_HOST, b);
      end
   endfunction

   function automatic int extract_byte(input logic [7:0] b, input logic last);
      int              first;
      int              c;
      int              i;
      logic [2:0]      still_alive;
      logic            hit;
      extract_rec_type r;
      first = awaited_recs.size();
      if (seen_http) begin
         scan_http_byte(b);
      end else if (pfx_alive != 3'd0) begin
         if (pfx_pos >= PREFIX_DEPTH) begin
            pfx_alive = 3'd0;
         end else begin
            pfx_bytes[pfx_pos] = b;
            still_alive = 3'd0;
            hit = 1'b0;
            for (c = 0; c < 3; c++) begin
               if (pfx_alive[c] && pfx_pos < cand_len(c) && cand_char(c, pfx_pos) == b) begin
                  still_alive[c] = 1'b1;
                  if (int'(pfx_pos) + 1 == cand_len(c))
                     hit = 1'b1;
               end
            end
            pfx_alive = still_alive;
            pfx_pos = pfx_pos + 3'd1;
            if (hit) begin
               seen_http = 1'b1;
               for (i = 0; i < pfx_pos && i < PREFIX_DEPTH; i++)
                  scan_http_byte(pfx_bytes[i]);
            end
         end
      end
      if (last) begin
         emit_rec(KIND_SUMMARY, 8'h00);
         clear_extractor();
      end
      if (awaited_recs.size() > first) begin
         r = awaited_recs.pop_back();
         r.eor = 1'b1;
         awaited_recs.push_back(r);
      end
      return awaited_recs.size() - first;
   endfunction

   function automatic void add_row(input logic [7:0] b, input logic last, input logic fixed,
                                   input extract_rec_type want);
      stim_row_type row;
      row.b     = b;
      row.last  = last;
      row.fixed = fixed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         add_row(s[i], 1'b0, 1'b0, '0);
   endfunction

   function automatic void push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         payload_bytes.push_back(s[i]);
   endfunction

   function automatic logic [7:0] content_byte();
      if ($urandom_range(0, 9) != 0)
         return 8'($urandom_range(32, 126));
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void build_payload();
      int    k;
      int    i;
      string s;
      payload_bytes.delete();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: begin
            case ($urandom_range(0, 2))
               0: push_text("GET ");
               1: push_text("POST ");
               default: push_text("HTTP/");
            endcase
            repeat ($urandom_range(0, 10)) payload_bytes.push_back(content_byte());
            if ($urandom_range(0, 4) == 0)
               push_text("Host: ");
            repeat ($urandom_range(0, 4)) payload_bytes.push_back(content_byte());
            case ($urandom_range(0, 3))
               0: begin
                  payload_bytes.push_back(CHAR_CR);
                  payload_bytes.push_back(CHAR_LF);
               end
               1: payload_bytes.push_back(CHAR_CR);
               2: payload_bytes.push_back(CHAR_LF);
               default: ;
            endcase
            case ($urandom_range(0, 3))
               0: push_text("Hos");
               1: push_text("H");
               default: ;
            endcase
            if ($urandom_range(0, 4) != 0)
               push_text("Host: ");
            repeat ($urandom_range(0, 8)) payload_bytes.push_back(content_byte());
            case ($urandom_range(0, 4))
               0: payload_bytes.push_back(CHAR_CR);
               1: payload_bytes.push_back(CHAR_LF);
               2: payload_bytes.push_back(CHAR_NUL);
               3: begin
                  payload_bytes.push_back(CHAR_LF);
                  push_text("Host: x");
               end
               default: ;
            endcase
            repeat ($urandom_range(0, 3)) payload_bytes.push_back(content_byte());
         end
         7, 8: begin
            case ($urandom_range(0, 2))
               0: s = "GET ";
               1: s = "POST ";
               default: s = "HTTP/";
            endcase
            k = $urandom_range(1, s.len());
            for (i = 0; i < k; i++)
               payload_bytes.push_back(s[i]);
            if ($urandom_range(0, 1)) begin
               void'(payload_bytes.pop_back());
               payload_bytes.push_back(8'($urandom_range(0, 255)));
            end
            repeat ($urandom_range(0, 4)) payload_bytes.push_back(content_byte());
         end
         default: begin
            repeat ($urandom_range(1, 12)) payload_bytes.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last, input logic fixed,
                            input extract_rec_type want);
      int gap;
      int n;
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      n = extract_byte(b, last);
      if (fixed) begin
         repeat (n) void'(awaited_recs.pop_back());
         awaited_recs.push_back(want);
      end
      @(negedge clock);
   endtask

   function automatic void compare_field(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
      end
   endfunction

   function automatic void check_transfer();
      extract_rec_type want;
      if (awaited_recs.size() == 0) begin
         mismatches++;
         $display("%0t: expected none, actual kind=%0d byte=%02h http=%0b host=%0b end=%0b",
                  $time, rsp_out_kind, rsp_out_byte, rsp_is_http, rsp_host_found,
                  rsp_end_of_run);
         return;
      end
      want = awaited_recs.pop_front();
      compare_field("out_kind", 8'(want.kind), 8'(rsp_out_kind));
      compare_field("out_byte", want.chr, rsp_out_byte);
      compare_field("is_http", 8'(want.http), 8'(rsp_is_http));
      compare_field("host_found", 8'(want.host), 8'(rsp_host_found));
      compare_field("end_of_run", 8'(want.eor), 8'(rsp_end_of_run));
   endfunction

   initial begin
      int gap;
      int calm_left;
      calm_left = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (calm_left > 0) begin
            calm_left--;
            gap = 0;
         end else begin
            gap = $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0)
               calm_left = $urandom_range(10, 40);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_transfer();
         @(negedge clock);
      end
   end

   initial begin
      int random_items;
      int i;
      random_items  = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      clear_extractor();

      add_row(8'h00, 1'b1, 1'b1, SUM_NOT_HTTP);
      add_row(8'hFF, 1'b1, 1'b1, SUM_NOT_HTTP);
      add_text("G");
      add_row("E", 1'b1, 1'b1, SUM_NOT_HTTP);
      add_text("GET ");
      add_row(CHAR_NUL, 1'b0, 1'b0, '0);
      add_text("Host: z");
      add_row(CHAR_NUL, 1'b1, 1'b1, SUM_HTTP_HOST);
      add_text("POST ");
      add_row(8'h7E, 1'b0, 1'b0, '0);
      add_row(8'h7F, 1'b0, 1'b0, '0);
      add_row(CHAR_CR, 1'b1, 1'b1, SUM_HTTP);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_byte(directed_rows[r].b, directed_rows[r].last, directed_rows[r].fixed,
                   directed_rows[r].want);

      while (random_items < RANDOM_ITEMS) begin
         build_payload();
         req_calm = ($urandom_range(0, 3) == 0);
         for (i = 0; i < payload_bytes.size(); i++) begin
            send_byte(payload_bytes[i], i == payload_bytes.size() - 1, 1'b0, '0);
            random_items++;
         end
      end
      req_valid <= 1'b0;

      while (awaited_recs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/hrlhe_pkg.sv
src/hrlhe_queue.sv
src/hrlhe_front.sv
src/hrlhe_back.sv
src/http_request_line_host_extractor.sv
src/hrlhe_checker.sv
tb/http_request_line_host_extractor_test.sv
